@@ hw/rtl/pse_pkg.sv @@
package pse_pkg;

    localparam int StackDepth = 128;
    localparam int SpW = $clog2(StackDepth);
    localparam int CntW = $clog2(StackDepth + 1);
    localparam int FifoDepth = 4;
    localparam int FifoW = $clog2(FifoDepth);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_SUB  = 2'd2;
    localparam logic [1:0] OP_MUL  = 2'd3;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam logic [7:0] CH_PLUS = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_STAR = 8'd42;
    localparam logic signed [31:0] NEG_ONE = 32'shFFFF0000;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] answer;
        logic               stack_overflow;
        logic               stack_underflow;
        logic               divide_by_zero;
    } t_out;

    // decoded item passed from front to back
    typedef struct packed {
        logic        is_op;
        logic        is_div;
        logic [1:0]  op;
        logic [3:0]  digit;
        logic        last;
    } t_cmd;

endpackage

@@ hw/rtl/postfix_stack_evaluator.sv @@
// Postfix evaluator over signed Q16.16. In the back end a digit is pushed directly; an
// operator pops two operands through the single stack RAM port, runs in the ALU, whose
// multiply/divide unit works one bit per cycle, and pushes its result; a final character
// then reads the top. A 4-entry queue decouples the input from the back end. One result
// waits in the output register; the back end runs on and stalls only when it has the
// next result ready before the waiting one is popped.
module postfix_stack_evaluator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pse_pkg::t_in  i_data,
    input  logic          push,
    output logic          full,
    output pse_pkg::t_out o_data,
    output logic          empty,
    input  logic          pop
);
    import pse_pkg::*;

    t_cmd cmd;
    logic cv, take;

    pse_front u_front (
        .i_clk, .i_rst_n, .i_data, .i_push(push), .o_full(full),
        .o_cmd(cmd), .o_valid(cv), .i_take(take)
    );

    pse_back u_back (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_valid(cv), .o_take(take),
        .o_data, .o_empty(empty), .i_pop(pop)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped");
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> $stable(o_data))
        else $error("waiting result changed");
endmodule

@@ hw/rtl/pse_ram.sv @@
module pse_ram #(
    parameter int Width = 32,
    parameter int Depth = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/pse_front.sv @@
module pse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pse_pkg::t_in   i_data,
    input  logic           i_push,
    output logic           o_full,
    output pse_pkg::t_cmd  o_cmd,
    output logic           o_valid,
    input  logic           i_take
);
    import pse_pkg::*;

    t_cmd             r_q [FifoDepth];
    logic [FifoW-1:0] r_wp, r_rp;
    logic [FifoW:0]   r_cnt;
    t_cmd             dec;
    logic             wr, rd;

    always_comb begin
        dec = '0;
        dec.last = i_data.last;
        if (i_data.symbol >= CH_ZERO && i_data.symbol <= CH_NINE) begin
            dec.digit = 4'(i_data.symbol - CH_ZERO);
        end else begin
            dec.is_op = 1'b1;
            unique case (i_data.symbol)
                CH_PLUS:  dec.op = OP_ADD;
                CH_MINUS: dec.op = OP_SUB;
                CH_STAR:  dec.op = OP_MUL;
                default:  dec.is_div = 1'b1;
            endcase
        end
    end

    assign o_full  = (r_cnt == (FifoW+1)'(FifoDepth));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FifoW+1)'(wr) - (FifoW+1)'(rd);
        end
    end
endmodule

@@ hw/rtl/pse_alu.sv @@
// Q16.16 unit: saturating add/subtract, iterative shift-add multiply and restoring divide, one bit a cycle.
module pse_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_div,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_done,
    output logic signed [31:0] o_res,
    output logic               o_dbz
);
    import pse_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]  r_st;
    logic [5:0]  r_i;
    logic        r_neg, r_div, r_dbz;
    logic [31:0] r_m;
    logic [47:0] r_num;
    logic [63:0] r_acc;
    logic [32:0] r_rem;
    logic signed [31:0] r_res;
    logic        r_done;
    logic [31:0] ma, mb;
    logic [32:0] rsh, rsub;
    logic [32:0] msum;
    logic signed [32:0] s33;
    logic [47:0] mag;

    assign ma = i_a[31] ? 32'(-i_a) : i_a;
    assign mb = i_b[31] ? 32'(-i_b) : i_b;
    assign rsh = {r_rem[31:0], r_num[47]};
    assign rsub = rsh - {1'b0, r_m};
    assign msum = {1'b0, r_acc[63:32]} + (r_acc[0] ? {1'b0, r_num[31:0]} : 33'h0);
    assign mag = r_div ? r_num : r_acc[63:16];

    always_comb begin
        s33 = '0;
        case (i_op)
            OP_ADD:  s33 = 33'(i_a) + 33'(i_b);
            default: s33 = 33'(i_a) - 33'(i_b);
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_dbz  = r_dbz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_start) begin
                    r_neg <= i_a[31] ^ i_b[31];
                    r_div <= i_div;
                    r_dbz <= 1'b0;
                    r_i <= '0;
                    r_m <= mb;
                    r_acc <= {32'h0, mb};
                    r_rem <= '0;
                    r_num <= {ma, 16'h0};
                    r_st <= S_FIN;
                    if (i_div) begin
                        if (i_b == '0) begin
                            r_dbz <= 1'b1;
                            r_res <= i_a[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
                            r_done <= 1'b1;
                            r_st <= S_IDLE;
                        end else begin
                            r_st <= S_DIV;
                        end
                    end else if (i_op == OP_MUL) begin
                        r_num <= {16'h0, ma};
                        r_st <= S_MUL;
                    end else begin
                        r_res <= (s33[32] != s33[31]) ?
                            (s33[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : s33[31:0];
                        r_done <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                S_MUL: begin
                    // add multiplicand into the upper half, shift the product right
                    r_acc <= {msum, r_acc[31:1]};
                    r_i <= r_i + 1'b1;
                    if (r_i == 6'd31) r_st <= S_FIN;
                end
                S_DIV: begin
                    if (!rsub[32]) begin
                        r_rem <= rsub;
                        r_num <= {r_num[46:0], 1'b1};
                    end else begin
                        r_rem <= rsh;
                        r_num <= {r_num[46:0], 1'b0};
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == 6'd47) r_st <= S_FIN;
                end
                S_FIN: begin
                    if (r_neg) begin
                        r_res <= (mag >= 48'h80000000) ? 32'sh80000000 : 32'(-mag);
                    end else begin
                        r_res <= (mag > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : mag[31:0];
                    end
                    r_done <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/pse_back.sv @@
module pse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pse_pkg::t_cmd  i_cmd,
    input  logic           i_valid,
    output logic           o_take,
    output pse_pkg::t_out  o_data,
    output logic           o_empty,
    input  logic           i_pop
);
    import pse_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD2  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_ALU  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_TOP  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]      r_st;
    logic [CntW-1:0] r_cnt;
    logic [2:0]      r_flg;
    t_cmd            r_cmd;
    logic signed [31:0] r_b;
    logic            r_bv, r_av;
    t_out            r_out;
    logic            r_ov;
    logic            out_load;
    logic            we;
    logic [SpW-1:0]  waddr, raddr;
    logic [31:0]     wdata, rdata;
    logic            alu_done, alu_dbz;
    logic signed [31:0] alu_res;
    logic            full_stk;

    assign full_stk = (r_cnt == CntW'(StackDepth));
    assign raddr = SpW'(r_cnt - 1'b1);

    pse_ram #(.Width(32), .Depth(StackDepth)) u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // op1 arrives from the RAM in the start cycle
    pse_alu u_alu (
        .i_clk, .i_rst_n, .i_start(r_st == S_ALU), .i_div(r_cmd.is_div),
        .i_op(r_cmd.op), .i_a(r_av ? rdata : NEG_ONE), .i_b(r_bv ? r_b : NEG_ONE),
        .o_done(alu_done), .o_res(alu_res), .o_dbz(alu_dbz)
    );

    always_comb begin
        we = 1'b0;
        wdata = alu_res;
        if (r_st == S_IDLE && i_valid && !i_cmd.is_op) begin
            we = !full_stk;
            wdata = {12'h0, i_cmd.digit, 16'h0};
        end else if (r_st == S_WAIT && alu_done) begin
            we = !full_stk;
        end
        waddr = SpW'(r_cnt);
    end

    // hold a new result until the waiting one is popped
    assign out_load = (r_st == S_OUT) && (!r_ov || i_pop);
    assign o_take  = (r_st == S_IDLE);
    assign o_empty = !r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_flg <= '0;
            r_ov <= 1'b0;
        end else begin
            if (out_load) r_ov <= 1'b1;
            else if (i_pop) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_cmd;
                    if (i_cmd.is_op) begin
                        r_st <= S_RD2;
                    end else begin
                        if (full_stk) r_flg[0] <= 1'b1;
                        else r_cnt <= r_cnt + 1'b1;
                        if (i_cmd.last) r_st <= S_TOP;
                    end
                end
                // each pop read goes through the registered RAM read port
                S_RD2: begin
                    r_bv <= r_cnt != '0;
                    if (r_cnt == '0) r_flg[1] <= 1'b1;
                    else r_cnt <= r_cnt - 1'b1;
                    r_st <= S_RD1;
                end
                S_RD1: begin
                    r_b <= rdata;
                    r_av <= r_cnt != '0;
                    if (r_cnt == '0) r_flg[1] <= 1'b1;
                    else r_cnt <= r_cnt - 1'b1;
                    r_st <= S_ALU;
                end
                S_ALU: begin
                    r_st <= S_WAIT;
                end
                S_WAIT: if (alu_done) begin
                    if (alu_dbz) r_flg[2] <= 1'b1;
                    if (full_stk) r_flg[0] <= 1'b1;
                    else r_cnt <= r_cnt + 1'b1;
                    r_st <= r_cmd.last ? S_TOP : S_IDLE;
                end
                S_TOP: r_st <= S_OUT;
                S_OUT: if (out_load) begin
                    r_out.answer <= (r_cnt == '0) ? NEG_ONE : rdata;
                    r_out.stack_overflow <= r_flg[0];
                    r_out.stack_underflow <= r_flg[1] | (r_cnt == '0);
                    r_out.divide_by_zero <= r_flg[2];
                    r_cnt <= '0;
                    r_flg <= '0;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
